>>> rtl/core/ale_pkg.sv
package ale_pkg;

    localparam int unsigned DEF_CAPACITY = 256;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned ST_W    = 2;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
    localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] item_value;
    } ale_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         element_count;
        logic [ST_W-1:0]          status;
    } ale_out_t;

endpackage

>>> rtl/core/array_list_engine_top.sv
// Flow: append, overwrite, rejected and unknown requests go from S_IDLE straight to S_DONE;
// reads pass through S_READ, and accepted inserts and removes through S_SHIFT, before S_DONE.
// S_DONE registers the result once the output register is free.
// One item at a time; the next input transfer is taken the cycle after the result is registered.
// Insert and remove move one entry per cycle through the store's read and write ports.
// Reset clears the element count and any pending result; store contents stay undefined.
module array_list_engine_top #(
    parameter int unsigned CAPACITY = ale_pkg::DEF_CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ale_pkg::ale_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ale_pkg::ale_out_t out_data
);

    import ale_pkg::*;

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_READ  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]     count_reg, count_next;
    logic              vld_reg, vld_next;
    logic              out_valid_reg, out_valid_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [AW-1:0]     dst_reg, dst_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] res_rd_reg, res_rd_next;
    logic [ST_W-1:0]   res_st_reg, res_st_next;
    ale_out_t          out_data_reg, out_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [CMPW-1:0]   idx_ext;
    logic [CMPW-1:0]   cnt_ext;
    logic              full;

    ale_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_ext = CMPW'(in_data.index);
    assign cnt_ext = CMPW'(count_reg);
    assign full    = (count_reg == CW'(CAPACITY));

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        vld_next       = 1'b0;
        out_valid_next = out_valid_reg & ~out_ready;
        rem_next       = rem_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        res_rd_next    = res_rd_reg;
        res_st_next    = res_st_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(count_reg);
        ram_wdata      = in_data.item_value;
        ram_raddr      = AW'(in_data.index);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_data.op;
                    idx_next    = in_data.index;
                    val_next    = in_data.item_value;
                    res_rd_next = '0;
                    res_st_next = ST_OK;
                    state_next  = S_DONE;
                    unique case (in_data.op)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (idx_ext > cnt_ext)
                            begin
                                res_st_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                // move entries [index, count) up, top one first
                                rem_next   = count_reg - CW'(in_data.index);
                                src_next   = AW'(count_reg - CW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                res_st_next = ST_RANGE;
                            end
                            else
                            begin
                                // move entries (index, count) down, lowest one first
                                rem_next   = count_reg - CW'(1) - CW'(in_data.index);
                                src_next   = AW'(in_data.index) + AW'(1);
                                state_next = S_SHIFT;
                            end
                        end
                        OP_OVERWRITE:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                res_st_next = ST_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(in_data.index);
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                res_st_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_st_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                ram_raddr = src_reg;
                // write back the entry read last cycle
                if (vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                end
                if (rem_reg != '0)
                begin
                    vld_next = 1'b1;
                    rem_next = rem_reg - CW'(1);
                    if (op_reg == OP_INSERT)
                    begin
                        dst_next = src_reg + AW'(1);
                        src_next = src_reg - AW'(1);
                    end
                    else
                    begin
                        dst_next = src_reg - AW'(1);
                        src_next = src_reg + AW'(1);
                    end
                end
                else if (!vld_reg)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(idx_reg);
                        ram_wdata  = val_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_READ:
            begin
                res_rd_next = ram_rdata;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.read_value    = res_rd_reg;
                    out_data_next.element_count = CNT_W'(count_reg);
                    out_data_next.status        = res_st_reg;
                    state_next                  = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            vld_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        res_rd_reg   <= res_rd_next;
        res_st_reg   <= res_st_next;
        out_data_reg <= out_data_next;
    end

endmodule

>>> rtl/core/ale_ram.sv
module ale_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
